### rtl/core/fvn_pkg.sv
// Shared types, constants and tables of the fractal value noise block.
`timescale 1ns / 1ps
package fvn_pkg;
   localparam int LATTICE_BITS_DEFAULT = 6;
   localparam int MAX_OCTAVES_DEFAULT = 8;
   localparam int ADDR_W = 12;
   localparam int WORD_W = 16;
   localparam int STEP_W = 24;
   localparam int PIX_W = 12;
   localparam int SUM_W = 18;
   localparam int CNT_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int RECIP_W = 22;
   localparam int RECIP_SHIFT = 21;

   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_STEP = 2'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // ceil(2^21 / d) for d = 1 .. 16; exact floor division of 16-bit words
   localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
      22'd2097152, 22'd1048576, 22'd699051, 22'd524288,
      22'd419431,  22'd349526,  22'd299594, 22'd262144,
      22'd233017,  22'd209716,  22'd190651, 22'd174763,
      22'd161320,  22'd149797,  22'd139811, 22'd131072
   };

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_POS, ST_EASE1, ST_EASE2, ST_W01,
      ST_TOP, ST_BOT, ST_MIX, ST_ACC, ST_DONE
   } state_type;

   typedef struct packed {
      logic      write_word;
      logic      start;
      logic      load_out;
      state_type phase;
   } cmd_type;

   typedef struct packed {
      logic none;
      logic last;
   } status_type;
endpackage

### rtl/core/fvn_ctrl.sv
// Controller state machine of the fractal value noise block.
`timescale 1ns / 1ps
module fvn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_cmd,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  fvn_pkg::status_type status,
   output fvn_pkg::cmd_type    cmd
);
   fvn_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fvn_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != fvn_pkg::ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.write_word = accept && (req_cmd == fvn_pkg::CMD_WRITE);
      cmd.start = accept && (req_cmd == fvn_pkg::CMD_SAMPLE);
      cmd.load_out = 1'b0;
      cmd.phase = state_ff;
      unique case (state_ff)
         fvn_pkg::ST_IDLE: begin
            if (cmd.start) state_in = fvn_pkg::ST_MUL;
         end
         fvn_pkg::ST_MUL: state_in = status.none ? fvn_pkg::ST_DONE : fvn_pkg::ST_POS;
         fvn_pkg::ST_POS: state_in = fvn_pkg::ST_EASE1;
         fvn_pkg::ST_EASE1: state_in = fvn_pkg::ST_EASE2;
         fvn_pkg::ST_EASE2: state_in = fvn_pkg::ST_W01;
         fvn_pkg::ST_W01: state_in = fvn_pkg::ST_TOP;
         fvn_pkg::ST_TOP: state_in = fvn_pkg::ST_BOT;
         fvn_pkg::ST_BOT: state_in = fvn_pkg::ST_MIX;
         fvn_pkg::ST_MIX: state_in = fvn_pkg::ST_ACC;
         fvn_pkg::ST_ACC: state_in = status.last ? fvn_pkg::ST_DONE : fvn_pkg::ST_POS;
         fvn_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = fvn_pkg::ST_IDLE;
            end
         end
         default: state_in = fvn_pkg::ST_IDLE;
      endcase
   end
endmodule

### rtl/core/fvn_datapath.sv
// Datapath: lattice memory, position, easing, interpolation and octave sum.
`timescale 1ns / 1ps
module fvn_datapath #(
   parameter int LATTICE_BITS = fvn_pkg::LATTICE_BITS_DEFAULT,
   parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fvn_pkg::cmd_type                 cmd,
   output fvn_pkg::status_type              status,
   input  logic [fvn_pkg::ADDR_W-1:0]       lattice_index,
   input  logic [fvn_pkg::WORD_W-1:0]       lattice_value,
   input  logic [fvn_pkg::PIX_W-1:0]        pixel_x,
   input  logic [fvn_pkg::PIX_W-1:0]        pixel_y,
   input  logic                             csr_write_enable,
   input  logic [fvn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fvn_pkg::STEP_W-1:0]       csr_data,
   output logic [fvn_pkg::SUM_W-1:0]        noise_sum
);
   localparam int BASE_W = fvn_pkg::STEP_W + fvn_pkg::PIX_W;
   localparam int POS_W = BASE_W + MAX_OCTAVES;
   localparam int K_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
   localparam int W = fvn_pkg::WORD_W;
   localparam int AW = fvn_pkg::ADDR_W;

   logic [W-1:0] mem [2**AW];
   logic [W-1:0] rdata_ff;
   logic [AW-1:0] raddr;

   logic [fvn_pkg::CNT_W-1:0] octave_count_ff;
   logic [fvn_pkg::STEP_W-1:0] x_step_ff, y_step_ff;
   logic [fvn_pkg::PIX_W-1:0] px_ff, py_ff;
   logic [BASE_W-1:0] bx_ff, by_ff;
   logic [K_W-1:0] k_ff;
   logic [fvn_pkg::CNT_W:0] count_ff;
   logic [LATTICE_BITS-1:0] c0_ff, r0_ff, c1, r1;
   logic [W-1:0] tx_ff, ty_ff, t2x_ff, t2y_ff;
   logic [W:0] sx_ff, sy_ff;
   logic [W-1:0] w00_ff, w01_ff, w10_ff, top_ff, bot_ff, val_ff;
   logic [fvn_pkg::SUM_W-1:0] sum_ff, out_ff;
   logic [POS_W-1:0] xs, ys;
   logic [fvn_pkg::RECIP_W-1:0] recip;
   logic [W+fvn_pkg::RECIP_W-1:0] qprod;
   logic [fvn_pkg::CNT_W:0] count_cap;

   function automatic logic [W-1:0] lerp(input logic [W-1:0] a, input logic [W-1:0] b,
                                         input logic [W:0] s);
      logic signed [W:0] diff;
      logic signed [2*W+2:0] prod;
      logic signed [W+2:0] step;
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      prod = diff * $signed({1'b0, s});
      step = prod[2*W+2:W];
      lerp = W'($signed({3'b000, a}) + step);
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [LATTICE_BITS-1:0] row,
                                             input logic [LATTICE_BITS-1:0] col);
      addr_of = AW'((AW'(row) << LATTICE_BITS) + AW'(col));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= 4'd4;
         x_step_ff <= 24'd65536;
         y_step_ff <= 24'd65536;
      end else if (csr_write_enable) begin
         case (csr_index)
            fvn_pkg::CSR_OCTAVE_COUNT: octave_count_ff <= csr_data[fvn_pkg::CNT_W-1:0];
            fvn_pkg::CSR_X_STEP: x_step_ff <= csr_data;
            fvn_pkg::CSR_Y_STEP: y_step_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_word) mem[lattice_index] <= lattice_value;
      rdata_ff <= mem[raddr];
   end

   assign c1 = c0_ff + 1'b1;
   assign r1 = r0_ff + 1'b1;
   assign xs = POS_W'(bx_ff) << k_ff;
   assign ys = POS_W'(by_ff) << k_ff;
   assign recip = fvn_pkg::RECIP_TABLE[4'(k_ff)];
   assign qprod = val_ff * recip;
   assign count_cap = ({1'b0, octave_count_ff} > (fvn_pkg::CNT_W+1)'(MAX_OCTAVES))
                      ? (fvn_pkg::CNT_W+1)'(MAX_OCTAVES) : {1'b0, octave_count_ff};
   assign status.none = (count_ff == '0);
   assign status.last = ((fvn_pkg::CNT_W+1)'(k_ff) + 1'b1 == count_ff);
   assign noise_sum = out_ff;

   always_comb begin
      case (cmd.phase)
         fvn_pkg::ST_EASE1: raddr = addr_of(r0_ff, c0_ff);
         fvn_pkg::ST_EASE2: raddr = addr_of(r0_ff, c1);
         fvn_pkg::ST_W01:   raddr = addr_of(r1, c0_ff);
         default:           raddr = addr_of(r1, c1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff <= pixel_x;
         py_ff <= pixel_y;
         count_ff <= count_cap;
      end
      if (cmd.load_out) out_ff <= sum_ff;
      case (cmd.phase)
         fvn_pkg::ST_MUL: begin
            bx_ff <= x_step_ff * px_ff;
            by_ff <= y_step_ff * py_ff;
            k_ff <= '0;
            sum_ff <= '0;
         end
         fvn_pkg::ST_POS: begin
            c0_ff <= xs[fvn_pkg::STEP_W +: LATTICE_BITS];
            r0_ff <= ys[fvn_pkg::STEP_W +: LATTICE_BITS];
            tx_ff <= xs[fvn_pkg::STEP_W-1 -: W];
            ty_ff <= ys[fvn_pkg::STEP_W-1 -: W];
         end
         fvn_pkg::ST_EASE1: begin
            t2x_ff <= W'((2*W)'(tx_ff * tx_ff) >> W);
            t2y_ff <= W'((2*W)'(ty_ff * ty_ff) >> W);
         end
         fvn_pkg::ST_EASE2: begin
            sx_ff <= (W+1)'(((2*W+2)'(t2x_ff) * (18'd196608 - {1'b0, tx_ff, 1'b0})) >> W);
            sy_ff <= (W+1)'(((2*W+2)'(t2y_ff) * (18'd196608 - {1'b0, ty_ff, 1'b0})) >> W);
            w00_ff <= rdata_ff;
         end
         fvn_pkg::ST_W01: w01_ff <= rdata_ff;
         fvn_pkg::ST_TOP: begin
            w10_ff <= rdata_ff;
            top_ff <= lerp(w00_ff, w01_ff, sx_ff);
         end
         fvn_pkg::ST_BOT: bot_ff <= lerp(w10_ff, rdata_ff, sx_ff);
         fvn_pkg::ST_MIX: val_ff <= lerp(top_ff, bot_ff, sy_ff);
         fvn_pkg::ST_ACC: begin
            sum_ff <= sum_ff + fvn_pkg::SUM_W'(qprod >> fvn_pkg::RECIP_SHIFT);
            k_ff <= k_ff + 1'b1;
         end
         default: ;
      endcase
   end
endmodule

### rtl/core/fractal_value_noise.sv
// Top level of the fractal 2-D value noise block.
`timescale 1ns / 1ps
// Channel   | Ports                                    | Direction
// request   | req_valid req_stall req_cmd req_lattice_* | in
//           | req_pixel_x req_pixel_y                   |
// response  | rsp_valid rsp_stall rsp_noise_sum         | out
// config    | csr_write_enable csr_index csr_data       | in
// A write request stores one lattice word.
// A sample request runs a multiply step, then eight steps per octave, set by
// the four reads of the single lattice memory port and the easing multiplies.
// Reset is synchronous and clears control state; the lattice is not cleared.
// A finished sum waits in the response register while the next request enters.
module fractal_value_noise #(
   parameter int LATTICE_BITS = fvn_pkg::LATTICE_BITS_DEFAULT,
   parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [fvn_pkg::ADDR_W-1:0]       req_lattice_index,
   input  logic [fvn_pkg::WORD_W-1:0]       req_lattice_value,
   input  logic [fvn_pkg::PIX_W-1:0]        req_pixel_x,
   input  logic [fvn_pkg::PIX_W-1:0]        req_pixel_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fvn_pkg::SUM_W-1:0]        rsp_noise_sum,
   input  logic                             csr_write_enable,
   input  logic [fvn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fvn_pkg::STEP_W-1:0]       csr_data
);
   fvn_pkg::cmd_type cmd;
   fvn_pkg::status_type status;

   // sequence the octave steps and own both handshakes
   fvn_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_cmd(req_cmd), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd)
   );

   // hold the lattice, registers and octave arithmetic
   fvn_datapath #(.LATTICE_BITS(LATTICE_BITS), .MAX_OCTAVES(MAX_OCTAVES)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .lattice_index(req_lattice_index), .lattice_value(req_lattice_value),
      .pixel_x(req_pixel_x), .pixel_y(req_pixel_y),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data),
      .noise_sum(rsp_noise_sum)
   );

`ifndef SYNTHESIS
   // a sample request keeps the block busy in the next cycle
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == fvn_pkg::CMD_SAMPLE) |=> req_stall)
      else $error("sample request did not start work");
   // a response appears only at the end of busy work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a sample in flight");
   // reset drops any pending response
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif
endmodule
